// File: src/lkv_pkg.sv
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_STORE  = 1'b1
  } lkv_mode_t;

  typedef logic [KEY_W-1:0] lkv_key_t;
  typedef logic [VAL_W-1:0] lkv_val_t;
  typedef logic [IDX_W-1:0] lkv_rank_t;
  typedef logic [CNT_W-1:0] lkv_cnt_t;

endpackage

// File: src/lkv_if.sv
interface lkv_req_if import lkv_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic signed [31:0] read_value;
  logic              evicted;

  modport source (output valid, output found, output read_value, output evicted,
                  input ready);
  modport sink (input valid, input found, input read_value, input evicted,
                output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// File: src/lru_key_value_cache_core.sv
// Fully associative key/value store with least recently used replacement.
// in_if: one transfer per request; mode selects lookup or store of key/value.
// out_if: exactly one transfer per request, in request order: found tells
//   whether the key was present, read_value carries the value on a lookup
//   hit (0 otherwise), evicted flags a store of a new key that displaced the
//   least recent entry.
// cfg_if: writes the capacity register (0 acts as 1, above 16 acts as 16).
//   Always ready; write only while no request is in flight.
// Pipeline: a request is held in the input register, then in the result
//   register that drives out_if. Throughput: one request per cycle while
//   out_if.ready is high; hit compare, rank update and replacement pick over
//   the 16-entry register file are combinational between the two registers.
// Reset (rst_n low, synchronous): all entries invalid, ranks and count
//   cleared, capacity back to 16, both pipeline registers empty.
// Stall: while out_if.ready is low the result holds; the input register
//   takes one more request if it is empty, then in_if.ready stays low until
//   the result moves on.
module lru_key_value_cache_core import lkv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lkv_req_if.sink     in_if,
  lkv_rsp_if.source   out_if,
  lkv_cfg_if.sink     cfg_if
);

  logic [CAP_W-1:0]   cap_r;

  logic               s1_valid_r;
  logic               s1_mode_r;
  lkv_key_t           s1_key_r;
  lkv_val_t           s1_value_r;

  lkv_key_t           key_r   [ENTRIES];
  lkv_val_t           value_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  lkv_rank_t          rank_r  [ENTRIES];
  lkv_rank_t          rank_nxt[ENTRIES];
  lkv_cnt_t           count_r, count_nxt;

  logic               out_valid_r;
  logic               out_found_r;
  lkv_val_t           out_read_r;
  logic               out_evicted_r;

  logic               fire;
  logic               is_store;
  logic [CMP_W-1:0]   cap_w;
  logic [CMP_W-1:0]   eff_cap;
  logic               full;
  logic [ENTRIES-1:0] hit_vec;
  logic               hit;
  lkv_val_t           hit_val;
  lkv_rank_t          hit_rank;
  lkv_cnt_t           count_m1;
  lkv_rank_t          lru_rank;
  logic               do_evict;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] kv_we;
  lkv_val_t           read_nxt;

  assign fire         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || fire;
  assign cfg_if.ready = 1'b1;
  assign is_store     = (s1_mode_r == MODE_STORE);

  always_comb begin
    cap_w = CMP_W'(cap_r);
    if (cap_w == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_w > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign full = (CMP_W'(count_r) >= eff_cap) && (count_r != '0);

  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == s1_key_r);
      hit_val    = hit_val | (value_r[i] & {VAL_W{hit_vec[i]}});
      hit_rank   = hit_rank | (rank_r[i] & {IDX_W{hit_vec[i]}});
    end
  end

  assign hit      = |hit_vec;
  assign count_m1 = count_r - CNT_W'(1);
  assign lru_rank = count_m1[IDX_W-1:0];
  assign do_evict = is_store && !hit && full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict_vec[i] = do_evict && valid_r[i] && (rank_r[i] == lru_rank);
    end
  end

  assign live     = valid_r & ~evict_vec;
  assign free_vec = ~live & (live + ENTRIES'(1));

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end else if (is_store) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_vec[i]) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (evict_vec[i]) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b0;
        end else if (live[i]) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      if (!do_evict) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  assign kv_we    = {ENTRIES{fire && is_store}} & (hit ? hit_vec : free_vec);
  assign read_nxt = (!is_store && hit) ? hit_val : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_if.valid) begin
        cap_r <= cfg_if.capacity;
      end
      if (in_if.valid && in_if.ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_mode_r  <= in_if.mode;
      s1_key_r   <= in_if.key;
      s1_value_r <= in_if.value;
    end
    if (fire) begin
      out_found_r   <= hit;
      out_read_r    <= read_nxt;
      out_evicted_r <= do_evict;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (kv_we[i]) begin
        key_r[i]   <= s1_key_r;
        value_r[i] <= s1_value_r;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.found      = out_found_r;
  assign out_if.read_value = out_read_r;
  assign out_if.evicted    = out_evicted_r;

endmodule

// File: src/lkv_monitor.sv
module lkv_monitor import lkv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_read_value,
  input logic        out_evicted
);

  logic [1:0] pending_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_read_value) && $stable(out_evicted))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pending_r != 2'd0)
    else $error("result transfer without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 2'd2)
    else $error("more requests in flight than pipeline stages");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_found && out_read_value == '0)
    else $error("eviction reported on a hit or with read data");

endmodule

bind lru_key_value_cache_core lkv_monitor u_lkv_monitor (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_found      (out_if.found),
  .out_read_value (out_if.read_value),
  .out_evicted    (out_if.evicted)
);

// File: test/lru_key_value_cache_core_tb.sv
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;
  import lkv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 143;

  typedef struct packed {
    logic     found;
    lkv_val_t read_value;
    logic     evicted;
  } lkv_result_t;

  class lru_shadow;
    lkv_key_t         slot_key [ENTRIES];
    lkv_val_t         slot_val [ENTRIES];
    bit               slot_live[ENTRIES];
    int unsigned      slot_age [ENTRIES];
    int unsigned      live_count;
    logic [CAP_W-1:0] capacity;
    lkv_result_t      expected_q[$];
    int unsigned      errors;

    function new();
      capacity = CAP_RESET;
      live_count = 0;
      errors = 0;
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_age[i] = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function void note_request(lkv_mode_t mode, lkv_key_t key, lkv_val_t value);
      lkv_result_t res;
      int          hit;
      int          victim;
      int          fresh;
      int unsigned limit;
      int unsigned oldest;
      res = '0;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_live[i] && slot_key[i] == key) hit = i;
      if (hit >= 0) begin
        res.found = 1'b1;
        if (mode == MODE_LOOKUP) res.read_value = slot_val[hit];
        else slot_val[hit] = value;
        oldest = slot_age[hit];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && slot_age[i] < oldest) slot_age[i]++;
        slot_age[hit] = 0;
      end else if (mode == MODE_STORE) begin
        limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
        if (live_count >= limit && live_count > 0) begin
          victim = -1;
          oldest = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
              victim = i;
              oldest = slot_age[i];
            end
          end
          slot_live[victim] = 1'b0;
          slot_age[victim] = 0;
          live_count--;
          res.evicted = 1'b1;
        end
        fresh = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!slot_live[i]) fresh = i;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_key[fresh] = key;
        slot_val[fresh] = value;
        slot_live[fresh] = 1'b1;
        slot_age[fresh] = 0;
        live_count++;
      end
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    endfunction

    function void check_result(logic found, lkv_val_t read_value, logic evicted);
      lkv_result_t exp_res;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", 32'h0, {30'h0, found, evicted});
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.found !== found) report("found", exp_res.found, found);
      if (exp_res.read_value !== read_value)
        report("read_value", exp_res.read_value, read_value);
      if (exp_res.evicted !== evicted) report("evicted", exp_res.evicted, evicted);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  lru_shadow   sb = new();

  int unsigned phase_cap [PHASES] = '{16, 1, 31, 4, 0, 9, 17, 2, 16, 7};
  int unsigned phase_pool[PHASES] = '{20, 2, 22, 6, 2, 12, 18, 3, 24, 9};

  lkv_req_if in_if();
  lkv_rsp_if out_if();
  lkv_cfg_if cfg_if();

  lru_key_value_cache_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL lru_key_value_cache_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.found, out_if.read_value, out_if.evicted);
      if (in_if.valid && in_if.ready)
        sb.note_request(lkv_mode_t'(in_if.mode), in_if.key, in_if.value);
      if (cfg_if.valid && cfg_if.ready) sb.set_capacity(cfg_if.capacity);
    end
  end

  initial begin
    logic [7:0]  ready_pattern;
    int unsigned hold;
    out_if.ready <= 1'b0;
    ready_pattern = 8'hff;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: ready_pattern = 8'hff;
          1: ready_pattern = 8'($urandom_range(1, 255));
          default: ready_pattern = 8'h01 << $urandom_range(0, 7);
        endcase
      end
      out_if.ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      hold--;
    end
  end

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send_item(lkv_mode_t mode, lkv_key_t key, lkv_val_t value);
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.key <= key;
    in_if.value <= value;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_requests();
    if (in_if.valid) in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_requests();
    cfg_if.valid <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_traffic(logic [CAP_W-1:0] cap, int unsigned pool_size,
                             int unsigned count);
    lkv_key_t  pool[$];
    lkv_key_t  key;
    lkv_val_t  value;
    lkv_mode_t mode;
    write_capacity(cap);
    repeat (pool_size)
      pool.push_back(($urandom_range(0, 7) == 0) ? corner_word() : $urandom);
    repeat (count) begin
      mode = $urandom_range(0, 1) ? MODE_STORE : MODE_LOOKUP;
      key = ($urandom_range(0, 11) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
      value = ($urandom_range(0, 7) == 0) ? corner_word() : $urandom;
      send_item(mode, key, value);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_LOOKUP;
    in_if.key <= '0;
    in_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.capacity <= CAP_RESET;
    burst_left = $urandom_range(1, 40);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(5'd2);
    send_item(MODE_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_item(MODE_STORE, 32'h8000_0000, 32'h7fff_ffff);
    send_item(MODE_STORE, 32'h7fff_ffff, 32'h8000_0000);
    send_item(MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_item(MODE_STORE, 32'hffff_ffff, 32'hffff_ffff);
    send_item(MODE_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);
    send_item(MODE_STORE, 32'h8000_0000, 32'h0000_0000);
    send_item(MODE_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
    send_item(MODE_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
    write_capacity(5'd0);
    send_item(MODE_STORE, 32'h0000_0000, 32'h5555_5555);
    send_item(MODE_STORE, 32'h0000_0001, 32'haaaa_aaaa);
    send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    write_capacity(5'd31);
    send_item(MODE_STORE, 32'h0000_0002, 32'h0000_0001);
    send_item(MODE_STORE, 32'h0000_0003, 32'h8000_0001);
    send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    send_item(MODE_LOOKUP, 32'h0000_0002, 32'h0000_0000);
    write_capacity(5'd17);
    send_item(MODE_STORE, 32'h0000_0004, 32'h0000_0004);

    for (int p = 0; p < PHASES; p++)
      run_traffic(CAP_W'(phase_cap[p]), phase_pool[p], PHASE_ITEMS);

    drain_requests();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS lru_key_value_cache_core");
    else
      $display("FAIL lru_key_value_cache_core");
    $finish;
  end

endmodule

// File: lru_key_value_cache_core.f
src/lkv_pkg.sv
src/lkv_if.sv
src/lru_key_value_cache_core.sv
src/lkv_monitor.sv
test/lru_key_value_cache_core_tb.sv
